// File: sv/vpa_pkg.sv
`timescale 1ns / 1ps
package vpa_pkg;

	localparam int SIZE_BITS    = 16;
	localparam int DEF_SEGMENTS = 16;
	localparam logic [SIZE_BITS-1:0] RESET_UNITS = 16'd100;

	typedef logic [SIZE_BITS-1:0] units_t;

	typedef struct packed {
		logic   busy;
		units_t size;
	} seg_t;

	typedef enum logic [2:0] {
		K_FIRST   = 3'd0,
		K_BEST    = 3'd1,
		K_WORST   = 3'd2,
		K_RELEASE = 3'd3,
		K_COMPACT = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFIT   = 3'd1,
		ST_FULL    = 3'd2,
		ST_BADSIZE = 3'd3,
		ST_NOTBUSY = 3'd4
	} status_t;

	typedef struct packed {
		status_t status;
		units_t  amount;
		units_t  offset_out;
		logic    ok;
	} res_t;

endpackage

// File: sv/vpa_seg_mem.sv
`timescale 1ns / 1ps
module vpa_seg_mem import vpa_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_SEGMENTS,
	parameter int IW = $clog2(MAX_SEGMENTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	input  units_t        total,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output seg_t          rd_data,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  seg_t          wr_data
);

	seg_t mem [MAX_SEGMENTS];
	seg_t rd_q;
	logic fresh_q;

	// entry 0 reads as one free segment of total units until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
		end else if (restart) begin
			fresh_q <= 1'b1;
		end else if (wr_en && wr_addr == '0) begin
			fresh_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (fresh_q && rd_addr == '0) begin
				rd_q <= '{busy: 1'b0, size: total};
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// File: sv/vpa_engine.sv
`timescale 1ns / 1ps
module vpa_engine import vpa_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_SEGMENTS,
	parameter int IW = $clog2(MAX_SEGMENTS),
	parameter int CW = $clog2(MAX_SEGMENTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    in_kind,
	input  units_t        in_size,
	input  units_t        in_offset,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res,
	output logic          rd_en,
	output logic [IW-1:0] rd_addr,
	input  seg_t          rd_data,
	output logic          wr_en,
	output logic [IW-1:0] wr_addr,
	output seg_t          wr_data
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SC_RD = 11'b00000000010,
		S_SC_EV = 11'b00000000100,
		S_DEC   = 11'b00000001000,
		S_PK_RD = 11'b00000010000,
		S_PK_WR = 11'b00000100000,
		S_PRE   = 11'b00001000000,
		S_MV_RD = 11'b00010000000,
		S_MV_WR = 11'b00100000000,
		S_POST  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

	state_t        state_q;
	logic [2:0]    op_q;
	units_t        req_q, where_q, start_q, free_q;
	logic [CW-1:0] cnt_q, new_cnt_q, idx_q, nbusy_q, mv_n_q;
	logic          found_q, n_valid_q, n_busy_q, p_busy_q;
	logic [IW-1:0] pick_q, mv_src_q, mv_dst_q, wr0_a_q, wr1_a_q;
	units_t        pick_size_q, pick_start_q, pick_diff_q, n_size_q, p_size_q;
	seg_t          prev_q, wr0_d_q, wr1_d_q;
	logic          wr0_en_q, wr1_en_q, mv_up_q;
	res_t          rs_q, out_q;
	logic          out_valid_q;

	units_t        diff;
	logic          fits, take, last, mn, mp;
	logic [IW-1:0] tgt;
	logic [CW-1:0] src_c;

	assign diff = rd_data.size - req_q;
	assign fits = !rd_data.busy && rd_data.size >= req_q;
	assign take = fits && (!found_q
		|| (op_q == K_BEST && diff < pick_diff_q)
		|| (op_q == K_WORST && diff > pick_diff_q));
	assign last = CW'(idx_q + 1'b1) == cnt_q;
	assign mn = n_valid_q && !n_busy_q;
	assign mp = pick_q != '0 && !p_busy_q;
	assign tgt = mp ? IW'(pick_q - 1'b1) : pick_q;
	assign src_c = CW'(pick_q) + CW'(1) + CW'(mn);

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = mv_dst_q;
		wr_data = rd_data;
		case (state_q)
			S_SC_RD, S_PK_RD: begin
				rd_en = 1'b1;
			end
			S_MV_RD: begin
				rd_en   = 1'b1;
				rd_addr = mv_src_q;
			end
			S_PK_WR: begin
				wr_en = rd_data.busy;
			end
			S_MV_WR: begin
				wr_en = 1'b1;
			end
			S_PRE: begin
				wr_en   = wr0_en_q;
				wr_addr = wr0_a_q;
				wr_data = wr0_d_q;
			end
			S_POST: begin
				wr_en   = wr1_en_q;
				wr_addr = wr1_a_q;
				wr_data = wr1_d_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				cnt_q <= CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= in_kind;
						req_q     <= in_size;
						where_q   <= in_offset;
						idx_q     <= '0;
						start_q   <= '0;
						free_q    <= '0;
						nbusy_q   <= '0;
						found_q   <= 1'b0;
						n_valid_q <= 1'b0;
						wr0_en_q  <= 1'b0;
						wr1_en_q  <= 1'b0;
						mv_n_q    <= '0;
						rs_q      <= '{status: ST_OK, amount: '0, offset_out: '0, ok: 1'b1};
						if (in_kind > K_COMPACT || (in_kind <= K_WORST && in_size == '0)) begin
							rs_q    <= '{status: ST_BADSIZE, amount: '0, offset_out: '0, ok: 1'b0};
							state_q <= S_DONE;
						end else begin
							state_q <= S_SC_RD;
						end
					end
				end
				S_SC_RD: state_q <= S_SC_EV;
				S_SC_EV: begin
					case (op_q)
						K_RELEASE: begin
							if (!found_q && start_q == where_q && rd_data.busy) begin
								found_q     <= 1'b1;
								pick_q      <= idx_q[IW-1:0];
								pick_size_q <= rd_data.size;
								p_busy_q    <= prev_q.busy;
								p_size_q    <= prev_q.size;
							end
							if (found_q && idx_q == CW'(pick_q) + CW'(1)) begin
								n_valid_q <= 1'b1;
								n_busy_q  <= rd_data.busy;
								n_size_q  <= rd_data.size;
							end
						end
						K_COMPACT: begin
							if (rd_data.busy) begin
								nbusy_q <= CW'(nbusy_q + 1'b1);
							end else begin
								free_q <= free_q + rd_data.size;
							end
						end
						default: begin
							if (take) begin
								found_q      <= 1'b1;
								pick_q       <= idx_q[IW-1:0];
								pick_size_q  <= rd_data.size;
								pick_start_q <= start_q;
								pick_diff_q  <= diff;
							end
						end
					endcase
					prev_q  <= rd_data;
					start_q <= start_q + rd_data.size;
					idx_q   <= CW'(idx_q + 1'b1);
					state_q <= last ? S_DEC : S_SC_RD;
				end
				S_DEC: begin
					new_cnt_q <= cnt_q;
					state_q   <= S_PRE;
					case (op_q)
						K_COMPACT: begin
							idx_q    <= '0;
							mv_dst_q <= '0;
							state_q  <= S_PK_RD;
						end
						K_RELEASE: begin
							if (!found_q) begin
								rs_q    <= '{status: ST_NOTBUSY, amount: '0, offset_out: '0,
									ok: 1'b0};
								state_q <= S_DONE;
							end else begin
								rs_q.amount <= pick_size_q;
								wr0_en_q    <= 1'b1;
								wr0_a_q     <= tgt;
								wr0_d_q     <= '{busy: 1'b0, size: pick_size_q
									+ (mn ? n_size_q : '0) + (mp ? p_size_q : '0)};
								mv_up_q     <= 1'b0;
								mv_src_q    <= src_c[IW-1:0];
								mv_dst_q    <= IW'(tgt + 1'b1);
								mv_n_q      <= CW'(cnt_q - src_c);
								new_cnt_q   <= CW'(cnt_q - CW'(mn) - CW'(mp));
							end
						end
						default: begin
							if (!found_q) begin
								rs_q    <= '{status: ST_NOFIT, amount: '0, offset_out: '0, ok: 1'b0};
								state_q <= S_DONE;
							end else if (pick_size_q != req_q && cnt_q == CNT_MAX) begin
								rs_q    <= '{status: ST_FULL, amount: '0, offset_out: '0, ok: 1'b0};
								state_q <= S_DONE;
							end else begin
								rs_q.offset_out <= pick_start_q;
								wr0_en_q <= 1'b1;
								wr0_a_q  <= pick_q;
								wr0_d_q  <= '{busy: 1'b1, size: req_q};
								if (pick_size_q != req_q) begin
									wr1_en_q  <= 1'b1;
									wr1_a_q   <= IW'(pick_q + 1'b1);
									wr1_d_q   <= '{busy: 1'b0, size: pick_size_q - req_q};
									mv_up_q   <= 1'b1;
									mv_src_q  <= IW'(cnt_q - 1'b1);
									mv_dst_q  <= cnt_q[IW-1:0];
									mv_n_q    <= CW'(cnt_q - CW'(1) - CW'(pick_q));
									new_cnt_q <= CW'(cnt_q + 1'b1);
								end
							end
						end
					endcase
				end
				S_PK_RD: state_q <= S_PK_WR;
				S_PK_WR: begin
					if (rd_data.busy) begin
						mv_dst_q <= IW'(mv_dst_q + 1'b1);
					end
					idx_q <= CW'(idx_q + 1'b1);
					if (last) begin
						rs_q.amount <= free_q;
						state_q     <= S_PRE;
						if (free_q != '0 || nbusy_q == '0) begin
							mv_up_q   <= 1'b1;
							mv_src_q  <= IW'(nbusy_q - 1'b1);
							mv_dst_q  <= IW'(nbusy_q);
							mv_n_q    <= nbusy_q;
							wr1_en_q  <= 1'b1;
							wr1_a_q   <= '0;
							wr1_d_q   <= '{busy: 1'b0, size: free_q};
							new_cnt_q <= CW'(nbusy_q + 1'b1);
						end else begin
							new_cnt_q <= nbusy_q;
						end
					end else begin
						state_q <= S_PK_RD;
					end
				end
				S_PRE: state_q <= (mv_n_q != '0) ? S_MV_RD : S_POST;
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					mv_n_q   <= CW'(mv_n_q - 1'b1);
					mv_src_q <= mv_up_q ? IW'(mv_src_q - 1'b1) : IW'(mv_src_q + 1'b1);
					mv_dst_q <= mv_up_q ? IW'(mv_dst_q - 1'b1) : IW'(mv_dst_q + 1'b1);
					state_q  <= (mv_n_q == CW'(1)) ? S_POST : S_MV_RD;
				end
				S_POST: begin
					cnt_q   <= new_cnt_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || res_ready) begin
						out_q       <= rs_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/variable_partition_allocator_unit.sv
`timescale 1ns / 1ps
// Segment allocator: an ordered table of up to MAX_SEGMENTS segments (size and busy mark)
// held in one single-port-read synchronous RAM. Each request first scans the table, reading
// and then evaluating each segment in turn. A compact then packs the busy segments to the
// front. Table entries are then moved one at a time (read, write) where needed to open or
// close a slot. Rejections of zero size or unknown kinds answer without a scan. The next
// request is taken once the previous one has finished, even while its result still waits
// on the output. Writing total_units restarts the table.
module variable_partition_allocator_unit import vpa_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_SEGMENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // size[15:0], offset[31:16]
	input  logic [7:0]  s_axis_tuser,  // kind[2:0], zero above
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // ok[0], offset_out[16:1], amount[32:17], status[35:33]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	units_t        total_q;
	logic          restart;
	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	seg_t          rd_data, wr_data;
	res_t          res;

	assign pready  = 1'b1;
	assign restart = psel && penable && pwrite && !paddr[2];
	assign prdata  = paddr[2] ? 32'd0 : {16'd0, total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= RESET_UNITS;
		end else if (restart) begin
			total_q <= pwdata[SIZE_BITS-1:0];
		end
	end

	vpa_seg_mem #(.MAX_SEGMENTS(MAX_SEGMENTS), .IW(IW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.total   (restart ? pwdata[SIZE_BITS-1:0] : total_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	vpa_engine #(.MAX_SEGMENTS(MAX_SEGMENTS), .IW(IW), .CW(CW)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser[2:0]),
		.in_size   (s_axis_tdata[15:0]),
		.in_offset (s_axis_tdata[31:16]),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	assign m_axis_tdata = {4'd0, res};

endmodule

// File: sv/vpa_checker.sv
`timescale 1ns / 1ps
module vpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// ok is set exactly for a zero status
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[35:33] == 3'd0)))
		else $error("ok and status disagree");

	// a rejected request reports no offset and no amount
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == 32'd0))
		else $error("rejected request carries data");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind variable_partition_allocator_unit vpa_checker u_vpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import vpa_pkg::*;

	localparam int NSEG = DEF_SEGMENTS;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [7:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	variable_partition_allocator_unit dut (.*);

	// predictor copy of the segment table
	units_t     mem_units;
	units_t     tbl_size [NSEG];
	logic       tbl_busy [NSEG];
	int         tbl_count;
	res_t       pending_results [$];
	int         errors;
	int         cycles;
	int         burst_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void table_restart();
		for (int i = 0; i < NSEG; i++) begin
			tbl_size[i] = '0;
			tbl_busy[i] = 1'b0;
		end
		tbl_size[0] = mem_units;
		tbl_count = 1;
	endfunction

	function automatic void table_drop(int idx);
		for (int j = idx; j < tbl_count - 1; j++) begin
			tbl_size[j] = tbl_size[j+1];
			tbl_busy[j] = tbl_busy[j+1];
		end
		tbl_count--;
	endfunction

	function automatic res_t predict_request(logic [2:0] kind, units_t sz, units_t where);
		res_t r;
		int pick, pick_start, pick_diff, start, d, idx;
		int free_total, n;
		r = '0;
		if (kind <= K_WORST) begin
			if (sz == 0) begin
				r.status = ST_BADSIZE;
				return r;
			end
			pick = -1;
			pick_start = 0;
			pick_diff = 0;
			start = 0;
			for (int i = 0; i < tbl_count; i++) begin
				if (!tbl_busy[i] && tbl_size[i] >= sz) begin
					d = tbl_size[i] - sz;
					if (kind == K_FIRST) begin
						pick = i;
						pick_start = start;
						break;
					end else if (kind == K_BEST) begin
						if (d == 0) begin
							pick = i;
							pick_start = start;
							break;
						end
						if (pick < 0 || d < pick_diff) begin
							pick = i;
							pick_start = start;
							pick_diff = d;
						end
					end else if (pick < 0 || d > pick_diff) begin
						pick = i;
						pick_start = start;
						pick_diff = d;
					end
				end
				start += tbl_size[i];
			end
			if (pick < 0) begin
				r.status = ST_NOFIT;
				return r;
			end
			if (tbl_size[pick] != sz) begin
				if (tbl_count >= NSEG) begin
					r.status = ST_FULL;
					return r;
				end
				for (int j = tbl_count; j > pick + 1; j--) begin
					tbl_size[j] = tbl_size[j-1];
					tbl_busy[j] = tbl_busy[j-1];
				end
				tbl_size[pick+1] = tbl_size[pick] - sz;
				tbl_busy[pick+1] = 1'b0;
				tbl_size[pick] = sz;
				tbl_count++;
			end
			tbl_busy[pick] = 1'b1;
			r.ok = 1'b1;
			r.offset_out = units_t'(pick_start);
			r.status = ST_OK;
		end else if (kind == K_RELEASE) begin
			start = 0;
			idx = tbl_count;
			for (int i = 0; i < tbl_count; i++) begin
				if (start == where && tbl_busy[i]) begin
					idx = i;
					break;
				end
				start += tbl_size[i];
			end
			if (idx >= tbl_count) begin
				r.status = ST_NOTBUSY;
				return r;
			end
			r.amount = tbl_size[idx];
			tbl_busy[idx] = 1'b0;
			if (idx + 1 < tbl_count && !tbl_busy[idx+1]) begin
				tbl_size[idx] += tbl_size[idx+1];
				table_drop(idx + 1);
			end
			if (idx > 0 && !tbl_busy[idx-1]) begin
				tbl_size[idx-1] += tbl_size[idx];
				table_drop(idx);
			end
			r.ok = 1'b1;
			r.status = ST_OK;
		end else if (kind == K_COMPACT) begin
			free_total = 0;
			n = 0;
			for (int i = 0; i < tbl_count; i++)
				if (!tbl_busy[i])
					free_total += tbl_size[i];
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_busy[i]) begin
					tbl_size[n] = tbl_size[i];
					tbl_busy[n] = 1'b1;
					n++;
				end
			end
			if (free_total > 0 || n == 0) begin
				for (int j = n; j > 0; j--) begin
					tbl_size[j] = tbl_size[j-1];
					tbl_busy[j] = tbl_busy[j-1];
				end
				tbl_size[0] = units_t'(free_total);
				tbl_busy[0] = 1'b0;
				n++;
			end
			tbl_count = n;
			r.ok = 1'b1;
			r.amount = units_t'(free_total);
			r.status = ST_OK;
		end else begin
			r.status = ST_BADSIZE;
		end
		return r;
	endfunction

	// result checker with its own stall pattern
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[35:0]);
			if (pending_results.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.ok !== want.ok)
					report("ok", got.ok, want.ok);
				if (got.offset_out !== want.offset_out)
					report("offset_out", got.offset_out, want.offset_out);
				if (got.amount !== want.amount)
					report("amount", got.amount, want.amount);
				if (got.status !== want.status)
					report("status", got.status, want.status);
			end
		end
	end

	always @(negedge clk) begin
		int phase;
		phase = cycles % 64;
		if (phase < 20)
			m_axis_tready <= 1'b1;
		else if (phase < 40)
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		else
			m_axis_tready <= ($urandom_range(0, 1) != 0);
	end

	task automatic send_request(input logic [2:0] kind, input int sz, input int where);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {where[15:0], sz[15:0]};
		s_axis_tuser <= {5'b0, kind};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_request(kind, units_t'(sz), units_t'(where)));
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_total(input int units);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= units;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mem_units = units_t'(units);
		table_restart();
	endtask

	// offset of a random busy segment, or a random value
	function automatic int busy_offset();
		int offs [$];
		int start;
		start = 0;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_busy[i])
				offs.push_back(start);
			start += tbl_size[i];
		end
		if (offs.size() == 0 || $urandom_range(0, 7) == 0)
			return $urandom_range(0, 65535);
		return offs[$urandom_range(0, offs.size() - 1)];
	endfunction

	task automatic test_directed();
		write_total(100);
		send_request(K_FIRST, 0, 0);
		send_request(K_FIRST, 10, 0);
		send_request(K_FIRST, 20, 0);
		send_request(K_BEST, 5, 0);
		send_request(K_RELEASE, 10, 0);
		send_request(K_RELEASE, 10, 0);
		send_request(K_BEST, 10, 0);
		send_request(K_WORST, 7, 0);
		send_request(K_FIRST, 101, 0);
		send_request(K_RELEASE, 0, 65535);
		send_request(K_COMPACT, 0, 0);
		send_request(3'd5, 1, 0);
		send_request(3'd7, 65535, 65535);
		for (int i = 0; i < 10; i++)
			send_request(K_FIRST, 1, 0);
		send_request(K_COMPACT, 0, 0);
		write_total(0);
		send_request(K_WORST, 1, 0);
		send_request(K_COMPACT, 0, 0);
		write_total(65535);
		send_request(K_FIRST, 65535, 0);
		send_request(K_COMPACT, 0, 0);
		send_request(K_RELEASE, 0, 0);
	endtask

	task automatic test_random(input int count, input int units);
		int k;
		int sz;
		write_total(units);
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 19);
			if (k < 9)
				send_request(logic'(0) ? 3'd0 : 3'($urandom_range(0, 2)),
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, units / 4 + 1), 0);
			else if (k < 17)
				send_request(K_RELEASE, $urandom, busy_offset());
			else if (k < 19)
				send_request(K_COMPACT, $urandom, $urandom);
			else
				send_request(3'($urandom_range(5, 7)), $urandom, $urandom);
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		mem_units = RESET_UNITS;
		table_restart();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(130, 100);
		test_random(90, 1);
		test_random(90, 65535);
		test_random(90, $urandom_range(2, 5000));
		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
sv/vpa_pkg.sv
sv/vpa_seg_mem.sv
sv/vpa_engine.sv
sv/variable_partition_allocator_unit.sv
sv/vpa_checker.sv
tb/sv/testbench.sv
